// File: sv/nns_pkg.sv
// nns_pkg: shared types, widths and codes of the nearest node search block
// depends on nothing; every other file of the block but nns_ram imports it
`timescale 1ns / 1ps

package nns_pkg;

   // table size and the widths that follow from it
   localparam int MAX_NODES = 64;
   localparam int ADDR_W    = $clog2(MAX_NODES);
   localparam int LIMIT_W   = $clog2(MAX_NODES + 1);

   // fixed field widths
   localparam int OP_W    = 1;
   localparam int IDX_W   = 6;
   localparam int COORD_W = 16;
   localparam int COUNT_W = 7;
   localparam int DIST_W  = 17;

   // arithmetic widths
   localparam int MAG_W  = COORD_W;          // |dx| of two 16-bit points fits 16 bits
   localparam int PROD_W = 2 * MAG_W;        // one square
   localparam int SQ_W   = PROD_W + 1;       // dx^2 + dy^2
   localparam int ROOT_W = DIST_W;           // floor sqrt of a SQ_W value
   localparam int RAD_W  = 2 * ROOT_W;       // radicand padded to an even width
   localparam int REM_W  = ROOT_W + 2;       // partial remainder
   localparam int STEP_W = $clog2(ROOT_W + 1);
   localparam int NODE_W = 2 * COORD_W;      // one table word: {y, x}

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ROOT,
      ST_SEND
   } nns_state_type;

   // status returned by the square root unit
   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } nns_root_type;

endpackage

// File: sv/nns_if.sv
// nns_req_if, nns_rsp_if: valid/ready channels of the nearest node search block
// depends on nns_pkg
`timescale 1ns / 1ps

interface nns_req_if import nns_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [IDX_W-1:0]          node_index;
   logic signed [COORD_W-1:0] x_mm;
   logic signed [COORD_W-1:0] y_mm;

   modport source (output valid, op, node_index, x_mm, y_mm, input ready);
   modport sink   (input valid, op, node_index, x_mm, y_mm, output ready);
endinterface

interface nns_rsp_if import nns_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  nearest_index;
   logic [DIST_W-1:0] distance_mm;

   modport source (output valid, nearest_index, distance_mm, input ready);
   modport sink   (input valid, nearest_index, distance_mm, output ready);
endinterface

// File: sv/nearest_node_search.sv
// nearest_node_search: top level of the 2-d nearest node search block
// depends on nns_pkg, nns_if, nns_ram, nns_isqrt
`timescale 1ns / 1ps

// Keeps a table of MAX_NODES node points (signed mm) in one ram word {y, x} per
// node and answers nearest node queries by a linear scan. A write word stores
// one node and gives no response; an index beyond the table is dropped. A
// query word scans entries 0 .. N-1 with N = max(min(node_count, MAX_NODES),
// 1), one ram read per cycle through a three stage distance pipe (|dx|,|dy|
// -> squares -> sum and compare, lowest index kept on ties), then takes the
// floor square root of the best squared distance in a bit-serial unit, one bit
// per cycle. One word is worked on at a time: req_chan.ready is high only while
// the block is idle, and stays low while a response waits. node_count is
// written through csr_wr_en / csr_wr_data; the user must write it only while
// idle, which the block does not enforce. A query must only cover entries that
// were written before.

module nearest_node_search import nns_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   nns_req_if.sink            req_chan,
   nns_rsp_if.source          rsp_chan
);

   // control
   nns_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] node_count_ff;
   logic               req_fire, wr_fire, query_fire;
   logic               wr_in_range;
   logic               root_start_ff;
   nns_root_type       root_status;

   // query setup
   logic [LIMIT_W-1:0] limit;
   logic [ADDR_W-1:0]  last_addr_ff, last_addr_in;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;

   // read issue
   logic              issue_on_ff;
   logic [ADDR_W-1:0] issue_addr_ff;
   logic [NODE_W-1:0] ram_rd_data;

   // distance pipe
   logic              rd_vld_ff, rd_last_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic              ab_vld_ff, ab_last_ff;
   logic [ADDR_W-1:0] ab_idx_ff;
   logic [MAG_W-1:0]  abx_ff, aby_ff;
   logic              sq_vld_ff, sq_last_ff;
   logic [ADDR_W-1:0] sq_idx_ff;
   logic [PROD_W-1:0] sqx_ff, sqy_ff;
   logic signed [COORD_W:0] dx, dy;
   logic [MAG_W-1:0]  adx, ady;
   logic [SQ_W-1:0]   dist_sq;

   // running best
   logic [SQ_W-1:0]   best_d_ff;
   logic [ADDR_W-1:0] best_idx_ff;

   // response register
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [DIST_W-1:0] rsp_dist_ff;

   assign req_fire    = req_chan.valid && req_chan.ready;
   assign wr_fire     = req_fire && (req_chan.op == OP_WRITE);
   assign query_fire  = req_fire && (req_chan.op == OP_QUERY);
   assign wr_in_range = 32'(req_chan.node_index) < 32'(MAX_NODES);

   // search limit and last address scanned, at least entry 0
   always_comb begin
      if (32'(node_count_ff) > 32'(MAX_NODES)) begin
         limit = LIMIT_W'(MAX_NODES);
      end else begin
         limit = LIMIT_W'(node_count_ff);
      end
      if (limit <= LIMIT_W'(1)) begin
         last_addr_in = '0;
      end else begin
         last_addr_in = ADDR_W'(limit - LIMIT_W'(1));
      end
   end

   // node table
   nns_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_fire && wr_in_range),
      .wr_addr (ADDR_W'(req_chan.node_index)),
      .wr_data ({req_chan.y_mm, req_chan.x_mm}),
      .rd_addr (issue_addr_ff),
      .rd_data (ram_rd_data)
   );

   // state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sq_vld_ff && sq_last_ff) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_status.done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   // read issue: one table entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_on_ff <= 1'b0;
      end else if (query_fire) begin
         issue_on_ff <= 1'b1;
      end else if (issue_on_ff && (issue_addr_ff == last_addr_ff)) begin
         issue_on_ff <= 1'b0;
      end
      if (query_fire) begin
         issue_addr_ff <= '0;
         last_addr_ff  <= last_addr_in;
         qx_ff         <= req_chan.x_mm;
         qy_ff         <= req_chan.y_mm;
      end else if (issue_on_ff) begin
         issue_addr_ff <= issue_addr_ff + 1'b1;
      end
   end

   // coordinate differences and magnitudes
   always_comb begin
      dx  = {ram_rd_data[COORD_W-1], ram_rd_data[COORD_W-1:0]} - {qx_ff[COORD_W-1], qx_ff};
      dy  = {ram_rd_data[NODE_W-1], ram_rd_data[NODE_W-1:COORD_W]} - {qy_ff[COORD_W-1], qy_ff};
      adx = dx[COORD_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      ady = dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      dist_sq = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
   end

   // distance pipe valid and tags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         ab_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue_on_ff;
         ab_vld_ff <= rd_vld_ff;
         sq_vld_ff <= ab_vld_ff;
      end
      rd_idx_ff  <= issue_addr_ff;
      rd_last_ff <= issue_addr_ff == last_addr_ff;
      ab_idx_ff  <= rd_idx_ff;
      ab_last_ff <= rd_last_ff;
      abx_ff     <= adx;
      aby_ff     <= ady;
      sq_idx_ff  <= ab_idx_ff;
      sq_last_ff <= ab_last_ff;
      sqx_ff     <= abx_ff * abx_ff;
      sqy_ff     <= aby_ff * aby_ff;
   end

   // running minimum; all ones start lets entry 0 always win
   always_ff @(posedge clock) begin
      if (query_fire) begin
         best_d_ff   <= '1;
         best_idx_ff <= '0;
      end else if (sq_vld_ff && (dist_sq < best_d_ff)) begin
         best_d_ff   <= dist_sq;
         best_idx_ff <= sq_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_start_ff <= 1'b0;
      end else begin
         root_start_ff <= sq_vld_ff && sq_last_ff;
      end
   end

   nns_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start_ff),
      .value  (best_d_ff),
      .status (root_status)
   );

   // response register
   always_ff @(posedge clock) begin
      if (root_status.done) begin
         rsp_index_ff <= IDX_W'(best_idx_ff);
         rsp_dist_ff  <= root_status.root;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = (state_ff == ST_SEND);
   assign rsp_chan.nearest_index = rsp_index_ff;
   assign rsp_chan.distance_mm   = rsp_dist_ff;

endmodule

// File: sv/nns_ram.sv
// nns_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module nns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/nns_isqrt.sv
// nns_isqrt: integer square root, one result bit per cycle
// depends on nns_pkg
`timescale 1ns / 1ps

module nns_isqrt import nns_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] value,
   output nns_root_type    status
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      // bring down the next two radicand bits
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = RAD_W'(value);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule

// File: sv/nns_checker.sv
// nns_checker: port level assertions for nearest_node_search, bound to the top
// depends on nns_pkg and nearest_node_search
`timescale 1ns / 1ps

module nns_checker import nns_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [OP_W-1:0]   req_op,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IDX_W-1:0]  rsp_nearest_index,
   input logic [DIST_W-1:0] rsp_distance_mm
);

   // a waiting response holds its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_index)
         && $stable(rsp_distance_mm))
      else $error("response word changed while stalled");

   // no new word is taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while response pending");

   // a table write gives no response and leaves the block ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_WRITE) |=> !rsp_valid && req_ready)
      else $error("table write produced a response or stalled");

   // a query keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_QUERY) |=> !req_ready && !rsp_valid)
      else $error("query did not occupy the block");

   // reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind nearest_node_search nns_checker u_nns_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_op            (req_chan.op),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_nearest_index (rsp_chan.nearest_index),
   .rsp_distance_mm   (rsp_chan.distance_mm)
);
